// ===== rtl/lis_pkg.sv =====
// Shared constants and types for the longest increasing subsequence core.
package lis_pkg;

  localparam int MAX_LEN = 1024;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [LEN_W-1:0]        len_t;

  // Element travelling down the cell row.
  typedef struct packed {
    val_t value;
    logic last;
    logic placed;
    len_t len;
  } item_t;

endpackage

// ===== rtl/lis_if.sv =====
// Valid/ready channel interfaces for input elements and length results.
interface lis_in_if
  import lis_pkg::*;
  ();
  logic valid;
  logic ready;
  val_t value;
  logic last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_out_if
  import lis_pkg::*;
  ();
  logic valid;
  logic ready;
  len_t lis_length;
  logic final_res;
  logic overflow;

  modport source (output valid, output lis_length, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input lis_length, input final_res, input overflow,
                  output ready);
endinterface

// ===== rtl/lis_cell.sv =====
// One tail cell: compares the passing element with its tail and forwards it.
module lis_cell
  import lis_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  len_t  idx,
  input  logic  in_v,
  input  item_t in_item,
  output logic  out_v,
  output item_t out_item
);

  logic  tail_v;
  val_t  tail;
  logic  hit;
  logic  app;
  item_t item_next;

  assign hit = tail_v && !in_item.placed && (tail >= in_item.value);
  assign app = !tail_v && !in_item.placed;

  always_comb begin
    item_next        = in_item;
    item_next.placed = in_item.placed || hit || app;
    item_next.len    = (tail_v || app) ? idx : in_item.len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (adv) begin
      out_v <= in_v;
      if (in_v) begin
        tail_v <= (tail_v || app) && !in_item.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_next;
      if (in_v && (hit || app)) begin
        tail <= in_item.value;
      end
    end
  end

endmodule

// ===== rtl/longest_increasing_subsequence_core.sv =====
// Top level: row of MAX_LEN tail cells followed by an output register.
// An accepted element is captured by the first cell and registered by each cell in
// turn; the output register captures the result from the last cell.
// Throughput: one element per cycle; the whole cell row advances in lockstep
// and stalls only while the output register holds an untaken result.
// Reset (rst, synchronous) empties every cell, clears the row and the overflow flag.
module longest_increasing_subsequence_core
  import lis_pkg::*;
(
  input logic      clk,
  input logic      rst,
  lis_in_if.sink   elem,
  lis_out_if.source res
);

  logic          adv;
  logic          chain_v    [0:MAX_LEN];
  item_t         chain_item [0:MAX_LEN];
  logic          ovf_seen;
  logic          ovf_now;
  item_t         done;

  assign adv        = !res.valid || res.ready;
  assign elem.ready = adv;

  always_comb begin
    chain_v[0]               = elem.valid;
    chain_item[0].value      = elem.value;
    chain_item[0].last       = elem.last;
    chain_item[0].placed     = 1'b0;
    chain_item[0].len        = '0;
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lis_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .idx      (LEN_W'(k + 1)),
      .in_v     (chain_v[k]),
      .in_item  (chain_item[k]),
      .out_v    (chain_v[k+1]),
      .out_item (chain_item[k+1])
    );
  end

  assign done    = chain_item[MAX_LEN];
  // element that found no tail and no free cell was dropped
  assign ovf_now = ovf_seen || !done.placed;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      ovf_seen  <= 1'b0;
    end else if (adv) begin
      res.valid <= chain_v[MAX_LEN];
      if (chain_v[MAX_LEN]) begin
        ovf_seen <= ovf_now && !done.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.lis_length <= done.len;
      res.final_res  <= done.last;
      res.overflow   <= ovf_now;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.lis_length <= LEN_W'(MAX_LEN))
    else $error("result length exceeds capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.overflow |-> res.lis_length == LEN_W'(MAX_LEN))
    else $error("overflow reported with table not full");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    elem.valid && elem.ready |=> chain_v[1])
    else $error("accepted transaction did not enter first cell");

  a_ovf_clear: assert property (@(posedge clk) disable iff (rst)
    adv && chain_v[MAX_LEN] && done.last |=> !ovf_seen)
    else $error("overflow flag survived end of sequence");

endmodule
